// ----- hdl/akf_pkg.sv -----
// Shared types and constants of the adaptive scalar Kalman filter.
`timescale 1ns / 1ps
`default_nettype none
package akf_pkg;

  localparam logic [2:0] REG_PROCESS_NOISE = 3'd0;
  localparam logic [2:0] REG_VARIANCE_GAIN = 3'd1;
  localparam logic [2:0] REG_NOISE_BASE    = 3'd2;
  localparam logic [2:0] REG_SMOOTH_WEIGHT = 3'd3;
  localparam logic [2:0] REG_NOISE_FLOOR   = 3'd4;
  localparam logic [2:0] REG_NOISE_CEILING = 3'd5;

  localparam logic [31:0] ONE_Q16       = 32'd65536;
  localparam logic [31:0] RST_PROC      = 32'd655;
  localparam logic [31:0] RST_VGAIN     = 32'd12189;
  localparam logic [31:0] RST_BASE      = 32'd88278;
  localparam logic [16:0] RST_WEIGHT    = 17'd9830;
  localparam logic [31:0] RST_FLOOR     = 32'd6554;
  localparam logic [31:0] RST_CEIL      = 32'd983040;
  localparam logic [31:0] RST_ESTIMATE  = 32'd642253;

  // Datapath step commands that the controller states issue.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SQUARE, OP_WIN_RD, OP_WIN_WR, OP_MEAN_HI, OP_MEAN_MUL,
    OP_NOISE, OP_CLAMP, OP_BLEND_A, OP_BLEND_B, OP_DIV_INIT, OP_DIV_STEP,
    OP_EST_MUL, OP_COMMIT
  } op_e;

  typedef struct packed {
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

endpackage
`default_nettype wire

// ----- hdl/akf_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module akf_ram #(
  parameter int Width = 32,
  parameter int Depth = 50
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

// ----- hdl/akf_datapath.sv -----
// Datapath: state registers, window memory, multipliers and gain divider.
`timescale 1ns / 1ps
`default_nettype none
module akf_datapath #(
  parameter int WindowLen = 50
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire akf_pkg::cmd_t        cmd_i,
  output akf_pkg::stat_t            stat_o,
  input  wire logic                 clearing_i,
  input  wire logic [$clog2(WindowLen)-1:0] clr_addr_i,
  input  wire logic [31:0]          sample_i,
  input  wire logic [31:0]          process_noise_i,
  input  wire logic [31:0]          variance_gain_i,
  input  wire logic [31:0]          noise_base_i,
  input  wire logic [16:0]          smoothing_weight_i,
  input  wire logic [31:0]          noise_floor_i,
  input  wire logic [31:0]          noise_ceiling_i,
  output logic [31:0]               estimate_o,
  output logic [31:0]               noise_o,
  output logic [16:0]               gain_o
);
  import akf_pkg::*;

  localparam int AW = $clog2(WindowLen);
  localparam int TW = 32 + $clog2(WindowLen + 1);
  // Reciprocal for total / WindowLen: floor(t*M >> S), exact for t < 2^TW.
  localparam int RS = TW + AW + 1;
  localparam logic [RS:0] RECIP = (RS + 1)'((2.0 ** RS) / WindowLen) + 1'b1;

  logic signed [31:0] est_q;
  logic [31:0] cov_q, prev_q, p1_q, sq_q, noise_q, r_q;
  logic [32:0] innov_q;
  logic [32:0] mag_q;
  logic        neg_q;
  logic [AW-1:0] pos_q;
  logic [TW-1:0] total_q;
  logic [63:0] prod_q;
  logic [63:0] acc_q;
  logic [33:0] den_q;
  logic [48:0] rem_q;
  logic [47:0] quo_q;
  logic [5:0]  dcnt_q;
  logic [16:0] k_q;
  logic [31:0] ram_rd;
  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0] ram_wd;

  assign ram_we   = clearing_i || (cmd_i.op == OP_WIN_WR);
  assign ram_addr = clearing_i ? clr_addr_i : pos_q;
  assign ram_wd   = clearing_i ? 32'd0 : sq_q;

  akf_ram #(.Width(32), .Depth(WindowLen)) u_win (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wd), .rdata_o(ram_rd)
  );

  logic [32:0] p1_sum;
  logic [16:0] w_eff;
  logic [TW-1:0] total_new;
  logic [48:0] rem_sh;
  logic [32:0] mag_n;
  logic signed [33:0] next_est;
  logic [31:0] inc;
  logic [16:0] k_val;

  always_comb begin
    p1_sum = {1'b0, cov_q} + {1'b0, process_noise_i};
    w_eff = (smoothing_weight_i > 17'd65536) ? 17'd65536 : smoothing_weight_i;
    total_new = total_q - TW'(ram_rd) + TW'(sq_q);
    rem_sh = {rem_q[47:0], quo_q[47]};
    mag_n = innov_q[32] ? (~innov_q + 33'd1) : innov_q;
    inc = neg_q ? 32'((prod_q + 64'hFFFF) >> 16) : 32'(prod_q >> 16);
    next_est = neg_q ? (34'(est_q) - $signed({2'b0, inc}))
                     : (34'(est_q) + $signed({2'b0, inc}));
    if (den_q == 0) k_val = '0;
    else if (quo_q > 48'd65536) k_val = 17'd65536;
    else k_val = quo_q[16:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q   <= RST_ESTIMATE;
      cov_q   <= ONE_Q16;
      prev_q  <= RST_BASE;
      pos_q   <= '0;
      total_q <= '0;
      dcnt_q  <= '0;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          p1_q    <= p1_sum[32] ? 32'hFFFFFFFF : p1_sum[31:0];
          innov_q <= 33'($signed(sample_i)) - 33'(est_q);
        end
        OP_SQUARE: begin
          mag_q  <= mag_n;
          neg_q  <= innov_q[32];
          prod_q <= 64'(mag_n) * 64'(mag_n);
        end
        OP_WIN_RD: begin
          if ((mag_q >> 24) != 0 || (prod_q >> 48) != 0) sq_q <= 32'hFFFFFFFF;
          else sq_q <= prod_q[47:16];
        end
        OP_WIN_WR: begin
          total_q <= total_new;
          pos_q   <= (32'(pos_q) >= WindowLen - 1) ? '0 : pos_q + 1'b1;
          // low half of total times reciprocal
          acc_q   <= 64'(total_new[18:0]) * 64'(RECIP);
        end
        // high half, then drop the low product's fraction bits
        OP_MEAN_HI:
          acc_q <= (64'(total_q[TW-1:19]) * 64'(RECIP) + (acc_q >> 19)) >> (RS - 19);
        OP_MEAN_MUL: prod_q <= 64'(acc_q[31:0]) * 64'(variance_gain_i);
        OP_NOISE: acc_q <= (prod_q >> 16) + 64'(noise_base_i);
        OP_CLAMP: begin
          if (acc_q < 64'(noise_floor_i)) noise_q <= noise_floor_i;
          else if (acc_q > 64'(noise_ceiling_i)) noise_q <= noise_ceiling_i;
          else noise_q <= acc_q[31:0];
        end
        OP_BLEND_A: prod_q <= 64'(w_eff) * 64'(noise_q);
        OP_BLEND_B: acc_q <= prod_q + 64'(17'd65536 - w_eff) * 64'(prev_q);
        OP_DIV_INIT: begin
          r_q    <= acc_q[47:16];
          prev_q <= acc_q[47:16];
          den_q  <= {2'b0, p1_q} + {2'b0, acc_q[47:16]};
          rem_q  <= '0;
          quo_q  <= {p1_q, 16'd0};
          dcnt_q <= 6'd48;
        end
        OP_DIV_STEP: begin
          if (rem_sh >= 49'(den_q)) begin
            rem_q <= rem_sh - 49'(den_q);
            quo_q <= {quo_q[46:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[46:0], 1'b0};
          end
          dcnt_q <= dcnt_q - 6'd1;
        end
        OP_EST_MUL: begin
          k_q    <= k_val;
          prod_q <= 64'(k_val) * 64'(mag_q);
        end
        OP_COMMIT: begin
          if (next_est > 34'sh7FFFFFFF) est_q <= 32'sh7FFFFFFF;
          else if (next_est < -34'sh80000000) est_q <= 32'sh80000000;
          else est_q <= next_est[31:0];
          cov_q <= 32'((64'(17'd65536 - k_q) * 64'(p1_q)) >> 16);
        end
        default: ;
      endcase
    end
  end

  assign stat_o.div_done = (dcnt_q == 6'd1);
  assign estimate_o = est_q;
  assign noise_o    = r_q;
  assign gain_o     = k_q;
endmodule
`default_nettype wire

// ----- hdl/akf_ctrl.sv -----
// Controller: clears the window memory after reset, sequences one item through the datapath, handles handshake.
`timescale 1ns / 1ps
`default_nettype none
module akf_ctrl #(
  parameter int WindowLen = 50
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output akf_pkg::cmd_t             cmd_o,
  input  wire akf_pkg::stat_t       stat_i,
  output logic                      clearing_o,
  output logic [$clog2(WindowLen)-1:0] clr_addr_o
);
  import akf_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SQUARE, S_WIN_RD, S_WIN_WR, S_MEAN_HI, S_MEAN, S_NOISE,
    S_CLAMP, S_BL_A, S_BL_B, S_DIV_INIT, S_DIV, S_EST, S_COMMIT, S_OUT
  } state_e;

  state_e state_q;
  logic [$clog2(WindowLen)-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == WindowLen - 1) state_q <= S_IDLE;
        end
        S_IDLE: if (in_valid_i) state_q <= S_SQUARE;
        S_SQUARE: state_q <= S_WIN_RD;
        S_WIN_RD: state_q <= S_WIN_WR;
        S_WIN_WR: state_q <= S_MEAN_HI;
        S_MEAN_HI: state_q <= S_MEAN;
        S_MEAN: state_q <= S_NOISE;
        S_NOISE: state_q <= S_CLAMP;
        S_CLAMP: state_q <= S_BL_A;
        S_BL_A: state_q <= S_BL_B;
        S_BL_B: state_q <= S_DIV_INIT;
        S_DIV_INIT: state_q <= S_DIV;
        S_DIV: if (stat_i.div_done) state_q <= S_EST;
        S_EST: state_q <= S_COMMIT;
        S_COMMIT: state_q <= S_OUT;
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    case (state_q)
      S_IDLE:     cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_SQUARE:   cmd_o.op = OP_SQUARE;
      S_WIN_RD:   cmd_o.op = OP_WIN_RD;
      S_WIN_WR:   cmd_o.op = OP_WIN_WR;
      S_MEAN_HI:  cmd_o.op = OP_MEAN_HI;
      S_MEAN:     cmd_o.op = OP_MEAN_MUL;
      S_NOISE:    cmd_o.op = OP_NOISE;
      S_CLAMP:    cmd_o.op = OP_CLAMP;
      S_BL_A:     cmd_o.op = OP_BLEND_A;
      S_BL_B:     cmd_o.op = OP_BLEND_B;
      S_DIV_INIT: cmd_o.op = OP_DIV_INIT;
      S_DIV:      cmd_o.op = OP_DIV_STEP;
      S_EST:      cmd_o.op = OP_EST_MUL;
      S_COMMIT:   cmd_o.op = OP_COMMIT;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign clearing_o  = (state_q == S_CLEAR);
  assign clr_addr_o  = clr_q;
endmodule
`default_nettype wire

// ----- hdl/adaptive_kalman_scalar_filter.sv -----
// Top level of the innovation-adaptive scalar Kalman filter.
// Usage:
//   s_axis carries one signed Q16.16 sample per item in tdata[31:0].
//   m_axis returns one result per item: estimate, smoothed noise, gain.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the six tuning registers; write
//   only while no item is in flight. Unknown indexes are ignored.
// Timing:
//   One item at a time. From accept to output valid, an item passes through
//   a fixed sequence of steps plus a restoring divider that forms the
//   Kalman gain one quotient bit per cycle.
//   s_axis_tready is low from accept until the result is taken.
// Reset:
//   Registers and filter state return to their defaults, then the window
//   memory is cleared, one entry per cycle, before the first item is
//   accepted.
// Stall:
//   The result holds on m_axis until tready; no new item enters meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_kalman_scalar_filter #(
  parameter int WINDOW_LEN = 50
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] sample
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [87:0]      m_axis_tdata,   // [31:0] estimate, [63:32] noise_used,
                                           // [80:64] gain_used, rest zero
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);
  import akf_pkg::*;

  logic [31:0] proc_q, vgain_q, base_q, floor_q, ceil_q;
  logic [16:0] weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_q   <= RST_PROC;
      vgain_q  <= RST_VGAIN;
      base_q   <= RST_BASE;
      weight_q <= RST_WEIGHT;
      floor_q  <= RST_FLOOR;
      ceil_q   <= RST_CEIL;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PROCESS_NOISE: proc_q   <= cfg_data_i;
        REG_VARIANCE_GAIN: vgain_q  <= cfg_data_i;
        REG_NOISE_BASE:    base_q   <= cfg_data_i;
        REG_SMOOTH_WEIGHT: weight_q <= cfg_data_i[16:0];
        REG_NOISE_FLOOR:   floor_q  <= cfg_data_i;
        REG_NOISE_CEILING: ceil_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cmd_t  cmd;
  stat_t stat;
  logic  clearing;
  logic [$clog2(WINDOW_LEN)-1:0] clr_addr;
  logic [31:0] est, noise;
  logic [16:0] gain;

  akf_ctrl #(.WindowLen(WINDOW_LEN)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .cmd_o(cmd), .stat_i(stat), .clearing_o(clearing), .clr_addr_o(clr_addr)
  );

  akf_datapath #(.WindowLen(WINDOW_LEN)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .clearing_i(clearing), .clr_addr_i(clr_addr),
    .sample_i(s_axis_tdata),
    .process_noise_i(proc_q), .variance_gain_i(vgain_q), .noise_base_i(base_q),
    .smoothing_weight_i(weight_q), .noise_floor_i(floor_q),
    .noise_ceiling_i(ceil_q),
    .estimate_o(est), .noise_o(noise), .gain_o(gain)
  );

  assign m_axis_tdata = {7'd0, gain, noise, est};
endmodule
`default_nettype wire
